FILE: rtl/core/rssft_pkg.sv
// Shared types, codes and lookup tables for the register stack spill/fill tracker.
// No dependencies; imported by rssft_calc and register_stack_spill_fill_tracker.
`timescale 1ns / 1ps

package rssft_pkg;

    localparam int STACK_SLOTS_DEFAULT = 8;
    localparam int COUNT_W             = 4;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_RESERVE = 3'd2,
        OP_FLUSH   = 3'd3,
        OP_REQUIRE = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_SPILL = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_FILL  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_MUL   = 2'd0,
        KIND_DIV   = 2'd1,
        KIND_POW   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // operand type codes
    localparam logic [2:0] TYPE_I = 3'd0;
    localparam logic [2:0] TYPE_C = 3'd4;
    localparam logic [2:0] TYPE_X = 3'd6;

    typedef struct packed {
        logic [2:0]         operation;
        logic [3:0]         value_type;
        logic [1:0]         arith_kind;
        logic [2:0]         left_type;
        logic [2:0]         right_type;
        logic [COUNT_W-1:0] wanted_depth;
    } item_t;

    typedef struct packed {
        cmd_t               command;
        logic [COUNT_W-1:0] first_count;
        logic [COUNT_W-1:0] second_count;
        logic [COUNT_W-1:0] depth_now;
        logic               underflow;
    } result_t;

    // stack slots taken by one value of a type: real 1, complex 2, others 0
    function automatic logic [1:0] slots_per_type(input logic [3:0] vtype);
        logic [1:0] n;
        begin
            unique case (vtype)
                4'd5, 4'd6, 4'd7:  n = 2'd1;
                4'd8, 4'd9, 4'd10: n = 2'd2;
                default:           n = 2'd0;
            endcase
            return n;
        end
    endfunction

    // operand type seven folds onto X
    function automatic logic [2:0] clamp_type(input logic [2:0] t);
        return (t > TYPE_X) ? TYPE_X : t;
    endfunction

    // temporaries for a power operator, by right then left operand type
    function automatic logic [2:0] power_temps(input logic [2:0] right,
                                               input logic [2:0] left);
        logic [2:0] base;
        logic [2:0] n;
        begin
            if (right == TYPE_I) begin
                base = 3'd7;
            end else if (right < TYPE_C) begin
                base = 3'd7;
            end else begin
                base = 3'd6;
            end
            if (right == TYPE_I && left == TYPE_I) begin
                n = 3'd0;
            end else if (left == TYPE_I) begin
                n = base;
            end else if (left < TYPE_C) begin
                n = base - 3'd1;
            end else begin
                n = base - 3'd2;
            end
            // apart from left = I, the right = I row is one higher than rows R..E
            if (right == TYPE_I && left != TYPE_I) begin
                n = n + 3'd1;
            end
            return n;
        end
    endfunction

endpackage

FILE: rtl/core/rssft_calc.sv
// Next-depth and command logic for one tracker operation.
// Depends on rssft_pkg.
`timescale 1ns / 1ps

module rssft_calc #(
    parameter int STACK_SLOTS = rssft_pkg::STACK_SLOTS_DEFAULT,
    parameter int DEPTH_W     = $clog2(STACK_SLOTS + 1)
) (
    input  rssft_pkg::item_t     item,
    input  logic [DEPTH_W-1:0]   depth,
    output logic [DEPTH_W-1:0]   depth_next,
    output rssft_pkg::result_t   result
);
    import rssft_pkg::*;

    // wide enough for depth plus up to seven temporaries
    localparam int SW = DEPTH_W + 3;
    localparam logic [SW-1:0] SLOTS = SW'(STACK_SLOTS);

    logic [SW-1:0] depth_w;
    logic [SW-1:0] n_w;
    logic [SW-1:0] need_w;
    logic [SW-1:0] sum_w;
    logic [SW-1:0] excess_w;
    logic [SW-1:0] wanted_w;
    logic [SW-1:0] first_w;
    logic [SW-1:0] second_w;
    logic [SW-1:0] new_w;
    logic [2:0]    left_c;
    logic [2:0]    right_c;
    logic [2:0]    need;
    cmd_t          cmd;
    logic          under;

    assign left_c  = clamp_type(item.left_type);
    assign right_c = clamp_type(item.right_type);
    assign depth_w = SW'(depth);
    assign n_w     = SW'(slots_per_type(item.value_type));

    always_comb begin
        need = 3'd0;
        unique case (kind_t'(item.arith_kind))
            KIND_MUL: begin
                if (left_c >= TYPE_C && right_c >= TYPE_C) need = 3'd1;
            end
            KIND_DIV: begin
                if (right_c >= TYPE_C) need = (left_c == TYPE_I) ? 3'd3 : 3'd2;
            end
            KIND_POW:   need = power_temps(right_c, left_c);
            KIND_OTHER: need = 3'd0;
        endcase
    end

    assign need_w   = SW'(need);
    assign wanted_w = (SW'(item.wanted_depth) > SLOTS) ? SLOTS : SW'(item.wanted_depth);

    always_comb begin
        cmd      = CMD_NONE;
        first_w  = '0;
        second_w = '0;
        under    = 1'b0;
        new_w    = depth_w;
        sum_w    = '0;
        excess_w = '0;
        unique case (item.operation)
            OP_PUSH: begin
                sum_w = depth_w + n_w;
                if (sum_w > SLOTS) begin
                    cmd      = CMD_SPILL;
                    second_w = depth_w;
                    new_w    = n_w;
                end else begin
                    new_w = sum_w;
                end
            end
            OP_POP: begin
                if (n_w > depth_w) begin
                    new_w = '0;
                    under = 1'b1;
                end else begin
                    new_w = depth_w - n_w;
                end
            end
            OP_RESERVE: begin
                sum_w = depth_w + need_w;
                if (sum_w > SLOTS) begin
                    excess_w = sum_w - SLOTS;
                    if (excess_w > depth_w) excess_w = depth_w;
                    new_w    = depth_w - excess_w;
                    cmd      = CMD_SPILL;
                    first_w  = depth_w - excess_w;
                    second_w = excess_w;
                end
            end
            OP_FLUSH: begin
                if (depth_w != '0) begin
                    cmd      = CMD_FLUSH;
                    second_w = depth_w;
                    new_w    = '0;
                end
            end
            OP_REQUIRE: begin
                if (wanted_w > depth_w) begin
                    cmd      = CMD_FILL;
                    first_w  = wanted_w - depth_w;
                    second_w = depth_w;
                    new_w    = wanted_w;
                end
            end
            OP_CLEAR: new_w = '0;
            default: ;  // unused codes leave the depth alone
        endcase
    end

    assign depth_next          = new_w[DEPTH_W-1:0];
    assign result.command      = cmd;
    assign result.first_count  = first_w[COUNT_W-1:0];
    assign result.second_count = second_w[COUNT_W-1:0];
    assign result.depth_now    = new_w[COUNT_W-1:0];
    assign result.underflow    = under;

endmodule

FILE: rtl/core/register_stack_spill_fill_tracker.sv
// Top level of the register stack spill/fill tracker: input and result registers.
// Depends on rssft_pkg and rssft_calc.
`timescale 1ns / 1ps

// Tracks the occupancy of a STACK_SLOTS-entry register stack and returns one
// command (none, spill, flush, fill) with its counts for every operation.
// Throughput is one operation per clock unless the master stalls. A result
// passes through the input register, then the result register, before it shows
// on the master side; a stalled master holds both stages. The single depth
// register is updated as each operation leaves the input register, so
// consecutive operations see each other's effect without bubbles.
// Counts of sixteen (STACK_SLOTS = 16) show modulo 16 in the 4-bit fields.
module register_stack_spill_fill_tracker #(
    parameter int STACK_SLOTS = rssft_pkg::STACK_SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [6:3] value_type, [8:7] arith_kind, [11:9] left_type,
    // [14:12] right_type, [18:15] wanted_depth, [23:19] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] command, [5:2] first_count, [9:6] second_count, [13:10] depth_now,
    // [14] underflow, [15] zero
    output logic [15:0] m_tdata
);
    import rssft_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_SLOTS + 1);

    logic               in_valid_reg;
    item_t              item_reg;
    logic               out_valid_reg;
    result_t            res_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    result_t            res_next;
    logic               out_load;
    logic               in_adv;

    assign out_load = !out_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    rssft_calc #(
        .STACK_SLOTS (STACK_SLOTS),
        .DEPTH_W     (DEPTH_W)
    ) u_calc (
        .item       (item_reg),
        .depth      (depth_reg),
        .depth_next (depth_next),
        .result     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            depth_reg     <= '0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (out_load) out_valid_reg <= in_valid_reg;
            if (in_adv) depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.operation    <= s_tdata[2:0];
            item_reg.value_type   <= s_tdata[6:3];
            item_reg.arith_kind   <= s_tdata[8:7];
            item_reg.left_type    <= s_tdata[11:9];
            item_reg.right_type   <= s_tdata[14:12];
            item_reg.wanted_depth <= s_tdata[18:15];
        end
        if (in_adv) res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.underflow, res_reg.depth_now,
                       res_reg.second_count, res_reg.first_count, res_reg.command};

endmodule

FILE: tb/sv/register_stack_spill_fill_tracker_tb.sv
// Self-checking testbench for register_stack_spill_fill_tracker: directed and random
// stack operations with random idling on both streams, checked by a scoreboard class.
// Depends on rssft_pkg and the tracker RTL.
`timescale 1ns / 1ps

module register_stack_spill_fill_tracker_tb;
    import rssft_pkg::*;

    localparam int SLOTS = STACK_SLOTS_DEFAULT;

    // operation codes the block leaves unused
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // operand types not named in the package
    localparam logic [2:0] TYPE_R   = 3'd1;
    localparam logic [2:0] TYPE_E   = 3'd3;
    localparam logic [2:0] TYPE_Q   = 3'd5;
    localparam logic [2:0] TYPE_BAD = 3'd7;

    // value types
    localparam logic [3:0] VT_LOGICAL = 4'd0;
    localparam logic [3:0] VT_REAL    = 4'd5;
    localparam logic [3:0] VT_CPLX_LO = 4'd8;
    localparam logic [3:0] VT_CPLX_MD = 4'd9;
    localparam logic [3:0] VT_CPLX_HI = 4'd10;
    localparam logic [3:0] VT_STRUCT  = 4'd12;
    localparam logic [3:0] VT_UNUSED  = 4'd15;

    // temporaries for a power operator, [right][left]
    localparam int POW_TEMPS [0:6][0:6] = '{
        '{0, 7, 7, 7, 6, 6, 6},
        '{7, 6, 6, 6, 5, 5, 5},
        '{7, 6, 6, 6, 5, 5, 5},
        '{7, 6, 6, 6, 5, 5, 5},
        '{6, 5, 5, 5, 4, 4, 4},
        '{6, 5, 5, 5, 4, 4, 4},
        '{6, 5, 5, 5, 4, 4, 4}
    };

    class stack_scoreboard;
        int        occupied;
        result_t   pending_q[$];
        int        errors;
        int        results_seen;
        int        spills;
        int        flushes;
        int        fills;
        int        underflows;

        function new();
            occupied     = 0;
            errors       = 0;
            results_seen = 0;
            spills       = 0;
            flushes      = 0;
            fills        = 0;
            underflows   = 0;
        endfunction

        function int slot_count(logic [3:0] vt);
            if (vt >= VT_REAL && vt < VT_CPLX_LO) return 1;
            if (vt >= VT_CPLX_LO && vt <= VT_CPLX_HI) return 2;
            return 0;
        endfunction

        // advance the occupancy by one accepted operation and queue its outcome
        function void note_input(logic [23:0] word);
            logic [2:0] op;
            logic [3:0] vt;
            logic [1:0] kind;
            logic [2:0] lt;
            logic [2:0] rt;
            int         wanted;
            int         n;
            int         excess;
            result_t    r;
            op     = word[2:0];
            vt     = word[6:3];
            kind   = word[8:7];
            lt     = (word[11:9] > TYPE_X) ? TYPE_X : word[11:9];
            rt     = (word[14:12] > TYPE_X) ? TYPE_X : word[14:12];
            wanted = word[18:15];
            r      = '0;
            r.command = CMD_NONE;
            case (op)
                OP_PUSH: begin
                    n = slot_count(vt);
                    if (occupied + n > SLOTS) begin
                        r.command      = CMD_SPILL;
                        r.second_count = 4'(occupied);
                        occupied       = n;
                    end else begin
                        occupied += n;
                    end
                end
                OP_POP: begin
                    n = slot_count(vt);
                    if (n > occupied) begin
                        occupied    = 0;
                        r.underflow = 1'b1;
                    end else begin
                        occupied -= n;
                    end
                end
                OP_RESERVE: begin
                    n = 0;
                    case (kind)
                        KIND_MUL: if (lt >= TYPE_C && rt >= TYPE_C) n = 1;
                        KIND_DIV: if (rt >= TYPE_C) n = (lt == TYPE_I) ? 3 : 2;
                        KIND_POW: n = POW_TEMPS[rt][lt];
                        default:  n = 0;
                    endcase
                    if (occupied + n > SLOTS) begin
                        excess = occupied + n - SLOTS;
                        if (excess > occupied) excess = occupied;
                        occupied      -= excess;
                        r.command      = CMD_SPILL;
                        r.first_count  = 4'(occupied);
                        r.second_count = 4'(excess);
                    end
                end
                OP_FLUSH: begin
                    if (occupied > 0) begin
                        r.command      = CMD_FLUSH;
                        r.second_count = 4'(occupied);
                        occupied       = 0;
                    end
                end
                OP_REQUIRE: begin
                    if (wanted > SLOTS) wanted = SLOTS;
                    if (wanted > occupied) begin
                        r.command      = CMD_FILL;
                        r.first_count  = 4'(wanted - occupied);
                        r.second_count = 4'(occupied);
                        occupied       = wanted;
                    end
                end
                OP_CLEAR: occupied = 0;
                default: ;
            endcase
            r.depth_now = 4'(occupied);
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [15:0] word);
            result_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual 0x%04h", $time, word);
                return;
            end
            want = pending_q.pop_front();
            results_seen++;
            compare_field("command", want.command, word[1:0]);
            compare_field("first_count", want.first_count, word[5:2]);
            compare_field("second_count", want.second_count, word[9:6]);
            compare_field("depth_now", want.depth_now, word[13:10]);
            compare_field("underflow", want.underflow, word[14]);
            case (want.command)
                CMD_SPILL: spills++;
                CMD_FLUSH: flushes++;
                CMD_FILL:  fills++;
                default: ;
            endcase
            if (want.underflow) underflows++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        steady;

    stack_scoreboard sb;

    register_stack_spill_fill_tracker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic [2:0] op, input logic [3:0] vt,
                             input logic [1:0] kind, input logic [2:0] lt,
                             input logic [2:0] rt, input logic [3:0] wanted);
        logic [23:0] word;
        word = {5'b0, wanted, rt, lt, kind, vt, op};
        while (!steady && $urandom_range(99) < 30) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(word);
        @(negedge aclk);
    endtask

    task automatic send_random();
        int         pick;
        logic [2:0] op;
        pick = $urandom_range(99);
        if (pick < 28)      op = OP_PUSH;
        else if (pick < 48) op = OP_POP;
        else if (pick < 70) op = OP_RESERVE;
        else if (pick < 80) op = OP_REQUIRE;
        else if (pick < 87) op = OP_FLUSH;
        else if (pick < 92) op = OP_CLEAR;
        else                op = 3'($urandom_range(7));
        send_item(op, 4'($urandom_range(15)), 2'($urandom_range(3)),
                  3'($urandom_range(7)), 3'($urandom_range(7)), 4'($urandom_range(15)));
    endtask

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        steady   = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // fill with real and complex values, then overflow into a spill
        send_item(OP_PUSH, VT_REAL, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_PUSH, VT_CPLX_HI, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_PUSH, VT_CPLX_HI, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_PUSH, VT_CPLX_HI, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_PUSH, VT_CPLX_MD, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        // types taking no slot, including an unused code
        send_item(OP_PUSH, VT_UNUSED, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_PUSH, VT_STRUCT, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_PUSH, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        // pop to empty, then underflow
        send_item(OP_POP, VT_CPLX_LO, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_POP, VT_REAL, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_POP, VT_UNUSED, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        // depth request beyond the stack saturates
        send_item(OP_REQUIRE, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_I, 4'd15);
        // operand type seven folds onto X; then reserves, fills, flushes, spare codes and a clear
        send_item(OP_RESERVE, VT_LOGICAL, KIND_POW, TYPE_BAD, TYPE_BAD, 4'd0);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_POW, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_POW, TYPE_R, TYPE_I, 4'd0);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_MUL, TYPE_C, TYPE_X, 4'd0);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_X, 4'd0);
        send_item(OP_REQUIRE, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_I, 4'd8);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_DIV, TYPE_I, TYPE_C, 4'd0);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_DIV, TYPE_E, TYPE_Q, 4'd0);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_DIV, TYPE_I, TYPE_R, 4'd0);
        send_item(OP_RESERVE, VT_LOGICAL, KIND_OTHER, TYPE_X, TYPE_X, 4'd0);
        send_item(OP_FLUSH, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_FLUSH, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_REQUIRE, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_I, 4'd0);
        send_item(OP_SPARE_6, VT_UNUSED, KIND_OTHER, TYPE_BAD, TYPE_BAD, 4'd15);
        send_item(OP_SPARE_7, VT_UNUSED, KIND_OTHER, TYPE_BAD, TYPE_BAD, 4'd15);
        send_item(OP_CLEAR, VT_LOGICAL, KIND_MUL, TYPE_I, TYPE_I, 4'd0);

        for (int i = 0; i < 1300; i++) begin
            steady = (i >= 500 && i < 800);
            send_random();
        end
        steady   = 1'b0;
        s_tvalid = 1'b0;

        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d operations with random stalls: %0d spills, %0d flushes, %0d fills,",
                 sb.results_seen, sb.spills, sb.flushes, sb.fills);
        $display("%0d pop underflows, %0d field mismatches", sb.underflows, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
